FILE: hdl/salru_pkg.sv
// shared types and codes for the set-associative lru tag store
`timescale 1ns / 1ps
package salru_pkg;

  // item codes
  localparam logic [1:0] MODE_ACCESS = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;

  // result codes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // register indexes, word address bits [3:2]
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  localparam int unsigned PADDR_W = 4;
  // wide enough for any set bit limit up to 15 and any way limit up to 31
  localparam int unsigned SB_EFF_W = 4;
  localparam int unsigned NW_EFF_W = 5;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways;
    logic [5:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic last;
  } cmd_t;

endpackage

FILE: hdl/salru_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module salru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/salru_ctrl.sv
// sequencer: accepts items and steps each access through read and update
`timescale 1ns / 1ps
module salru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        mode,
  output logic              busy,
  output salru_pkg::cmd_t   cmd
);
  import salru_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  state_t state;
  logic   second;   // a modify still owes its second access

  logic is_access;
  assign is_access = (mode == MODE_ACCESS) || (mode == MODE_MODIFY);

  always_comb begin
    cmd.capture = (state == S_IDLE) && start;
    cmd.read    = (state == S_READ);
    cmd.update  = (state == S_EVAL);
    cmd.last    = !second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      busy   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && is_access) begin
            state  <= S_READ;
            second <= (mode == MODE_MODIFY);
            busy   <= 1'b1;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (second) begin
            second <= 1'b0;
            state  <= S_READ;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/salru_dp.sv
// datapath: address split, set row lookup, lru update and totals
`timescale 1ns / 1ps
module salru_dp #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  salru_pkg::cfg_t       cfg,
  input  salru_pkg::cmd_t       cmd,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  strobe,
  output logic [1:0]            outcome,
  output logic                  last,
  output logic [31:0]           hit_count,
  output logic [31:0]           miss_count,
  output logic [31:0]           eviction_count
);
  import salru_pkg::*;

  localparam int unsigned SETS = 1 << MAX_SET_BITS;
  localparam int unsigned SW   = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
  localparam int unsigned RW   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned MW   = RW + 1;
  localparam int unsigned META_W = MAX_WAYS * MW;
  localparam int unsigned TAG_W  = MAX_WAYS * ADDR_WIDTH;

  // effective configuration
  logic [SB_EFF_W-1:0] sb_eff;
  logic [NW_EFF_W-1:0] nw_eff;
  logic [SW-1:0]       idx_mask;
  logic [6:0]          tag_shift;
  logic [ADDR_WIDTH-1:0] off_shifted;

  always_comb begin
    if ({1'b0, cfg.set_bits} > SB_EFF_W'(MAX_SET_BITS)) begin
      sb_eff = SB_EFF_W'(MAX_SET_BITS);
    end else begin
      sb_eff = {1'b0, cfg.set_bits};
    end
    if (cfg.ways == 4'd0) begin
      nw_eff = NW_EFF_W'(1);
    end else if ({1'b0, cfg.ways} > NW_EFF_W'(MAX_WAYS)) begin
      nw_eff = NW_EFF_W'(MAX_WAYS);
    end else begin
      nw_eff = {1'b0, cfg.ways};
    end
    idx_mask    = ~({SW{1'b1}} << sb_eff);
    tag_shift   = 7'(sb_eff) + 7'(cfg.block_bits);
    off_shifted = address >> cfg.block_bits;
  end

  // captured access
  logic [SW-1:0]         set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic                  row_ok_q;
  logic [SETS-1:0]       row_init;   // row written since reset

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q <= off_shifted[SW-1:0] & idx_mask;
      tag_q <= address >> tag_shift;   // shifts of ADDR_WIDTH or more give zero
    end
  end

  logic [META_W-1:0] meta_rd, meta_wr;
  logic [TAG_W-1:0]  tag_rd, tag_wr;

  salru_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_q),
    .wdata (meta_wr),
    .re    (cmd.read),
    .raddr (set_q),
    .rdata (meta_rd)
  );

  salru_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_q),
    .wdata (tag_wr),
    .re    (cmd.read),
    .raddr (set_q),
    .rdata (tag_rd)
  );

  // lookup and replacement
  logic [MAX_WAYS-1:0]   valid, in_use, hit, cand, beaten;
  logic [RW-1:0]         rank [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tag  [MAX_WAYS];
  logic                  hit_any, empty_any, fill;
  logic [RW-1:0]         hit_w, empty_w, victim_w, pick, limit;
  outcome_t              res;

  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_w     = '0;
    empty_w   = '0;
    victim_w  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      valid[w]  = row_ok_q & meta_rd[w*MW + RW];
      rank[w]   = row_ok_q ? meta_rd[w*MW +: RW] : '0;
      tag[w]    = tag_rd[w*ADDR_WIDTH +: ADDR_WIDTH];
      in_use[w] = NW_EFF_W'(w) < nw_eff;
      hit[w]    = in_use[w] && valid[w] && (tag[w] == tag_q);
      cand[w]   = in_use[w] && valid[w];
    end
    // valid ranks in a set are distinct, so one candidate is beaten by none
    for (int w = 0; w < MAX_WAYS; w++) begin
      beaten[w] = 1'b0;
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (cand[v] && rank[v] > rank[w]) begin
          beaten[w] = 1'b1;
        end
      end
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_any = 1'b1;
        hit_w   = RW'(w);
      end
      if (in_use[w] && !valid[w]) begin
        empty_any = 1'b1;
        empty_w   = RW'(w);
      end
      if (cand[w] && !beaten[w]) begin
        victim_w = RW'(w);
      end
    end

    fill = 1'b0;
    if (hit_any) begin
      res   = OUT_HIT;
      pick  = hit_w;
      limit = rank[hit_w];
    end else if (empty_any) begin
      res   = OUT_FILL;
      pick  = empty_w;
      limit = '1;
      fill  = 1'b1;
    end else begin
      res   = OUT_EVICT;
      pick  = victim_w;
      limit = rank[victim_w];
    end

    // promote the picked line, age the younger valid lines
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (RW'(w) == pick) begin
        meta_wr[w*MW + RW]  = 1'b1;
        meta_wr[w*MW +: RW] = '0;
        tag_wr[w*ADDR_WIDTH +: ADDR_WIDTH] = hit_any ? tag[w] : tag_q;
      end else begin
        meta_wr[w*MW + RW]  = valid[w];
        meta_wr[w*MW +: RW] = (valid[w] && (fill || rank[w] < limit)) ?
                              RW'(rank[w] + 1'b1) : rank[w];
        tag_wr[w*ADDR_WIDTH +: ADDR_WIDTH] = tag[w];
      end
    end
  end

  // row flags, totals and result beat
  outcome_t outcome_q;
  assign outcome = outcome_q;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      row_ok_q <= row_init[set_q];
    end
    if (cmd.update) begin
      outcome_q <= res;
      last      <= cmd.last;
    end
    if (rst) begin
      row_init       <= '0;
      strobe         <= 1'b0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else begin
      strobe <= cmd.update;
      if (cmd.update) begin
        row_init[set_q] <= 1'b1;
        if (res == OUT_HIT) begin
          if (hit_count != '1) hit_count <= hit_count + 32'd1;
        end else begin
          if (miss_count != '1) miss_count <= miss_count + 32'd1;
          if (res == OUT_EVICT && eviction_count != '1) begin
            eviction_count <= eviction_count + 32'd1;
          end
        end
      end
    end
  end

endmodule

FILE: hdl/set_associative_lru_cache_model.sv
// Set-associative tag store with lru replacement. A load/store item makes
// one access and a modify two; an instruction yields no result. A new item
// is taken only in idle, after busy drops. Each access does a registered read
// of its set row, then updates and writes the row back. Each result is a
// one-cycle beat on strobe, registered from the update of its access; the
// receiver cannot stall, so it must take every beat.
// Reset clears the per-set flags at once; no clearing pass is needed.
`timescale 1ns / 1ps
module set_associative_lru_cache_model #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode,
  input  logic [ADDR_WIDTH-1:0]           address,
  output logic                            strobe,
  output logic [1:0]                      outcome,
  output logic                            last,
  output logic [31:0]                     hit_count,
  output logic [31:0]                     miss_count,
  output logic [31:0]                     eviction_count,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [salru_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import salru_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits   <= 3'd4;
      cfg.ways       <= 4'd1;
      cfg.block_bits <= 6'd4;
    end else if (wr_beat) begin
      unique case (paddr[3:2])
        REG_SET_BITS:   cfg.set_bits   <= pwdata[2:0];
        REG_WAYS:       cfg.ways       <= pwdata[3:0];
        REG_BLOCK_BITS: cfg.block_bits <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SET_BITS:   prdata = {29'd0, cfg.set_bits};
      REG_WAYS:       prdata = {28'd0, cfg.ways};
      REG_BLOCK_BITS: prdata = {26'd0, cfg.block_bits};
      default:        prdata = 32'd0;
    endcase
  end

  salru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .busy  (busy),
    .cmd   (cmd)
  );

  salru_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .address        (address),
    .strobe         (strobe),
    .outcome        (outcome),
    .last           (last),
    .hit_count      (hit_count),
    .miss_count     (miss_count),
    .eviction_count (eviction_count)
  );

endmodule
